>>> sv/deq_pkg.sv
// deq_pkg: shared constants, codes, command word and index helpers for the
// double-ended queue core. No dependencies; used by every deq module.
`default_nettype none

package deq_pkg;

  localparam int DEPTH   = 128;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PW    = 1;
  localparam int CQ_CW    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_SIZE       = 3'd6,
    OP_EMPTY      = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // decoded command word handed from front to back
  typedef struct packed {
    op_t               op;
    logic              is_push;
    logic              is_pop;
    logic              is_peek;
    logic              at_back;
    logic [WORD_W-1:0] value;
  } cmd_t;

  function automatic idx_t idx_inc(input idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

`default_nettype wire

>>> sv/deq_front.sv
// deq_front: input handshake and operation decode into command words.
// Depends on deq_pkg; feeds deq_cmd_queue.
`default_nettype none

module deq_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [deq_pkg::OP_W-1:0]      in_operation,
  input  wire logic signed [deq_pkg::WORD_W-1:0] in_push_value,
  input  wire logic                          cq_full,
  output logic                               cq_wr,
  output deq_pkg::cmd_t                      cq_wdata
);

  deq_pkg::op_t op;

  assign op       = deq_pkg::op_t'(in_operation);
  assign in_stall = cq_full;
  assign cq_wr    = in_valid && !cq_full;

  always_comb begin
    cq_wdata         = '0;
    cq_wdata.op      = op;
    cq_wdata.value   = in_push_value;
    unique case (op)
      deq_pkg::OP_PUSH_FRONT: cq_wdata.is_push = 1'b1;
      deq_pkg::OP_PUSH_BACK: begin
        cq_wdata.is_push = 1'b1;
        cq_wdata.at_back = 1'b1;
      end
      deq_pkg::OP_POP_FRONT: cq_wdata.is_pop = 1'b1;
      deq_pkg::OP_POP_BACK: begin
        cq_wdata.is_pop  = 1'b1;
        cq_wdata.at_back = 1'b1;
      end
      deq_pkg::OP_PEEK_FRONT: cq_wdata.is_peek = 1'b1;
      deq_pkg::OP_PEEK_BACK: begin
        cq_wdata.is_peek = 1'b1;
        cq_wdata.at_back = 1'b1;
      end
      default: ;
    endcase
  end

  // a word is never written into a full command queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cq_wr |-> !cq_full)
    else $error("command written while queue full");

endmodule

`default_nettype wire

>>> sv/deq_cmd_queue.sv
// deq_cmd_queue: two-entry command queue between front and back.
// Depends on deq_pkg.
`default_nettype none

module deq_cmd_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr,
  input  wire deq_pkg::cmd_t wdata,
  output logic        full,
  input  wire logic   rd,
  output logic        rvalid,
  output deq_pkg::cmd_t rdata
);

  deq_pkg::cmd_t              slot_r [deq_pkg::CQ_DEPTH];
  logic [deq_pkg::CQ_PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [deq_pkg::CQ_PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [deq_pkg::CQ_CW-1:0]  cnt_r, cnt_nxt;
  logic                       do_rd;

  assign full   = (cnt_r == deq_pkg::CQ_CW'(deq_pkg::CQ_DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = slot_r[rd_ptr_r];
  assign do_rd  = rd && rvalid;

  always_comb begin
    wr_ptr_nxt = wr ? deq_pkg::CQ_PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? deq_pkg::CQ_PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr && !do_rd) begin
      cnt_nxt = deq_pkg::CQ_CW'(cnt_r + 1'b1);
    end else if (!wr && do_rd) begin
      cnt_nxt = deq_pkg::CQ_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= deq_pkg::CQ_CW'(deq_pkg::CQ_DEPTH))
    else $error("command queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == deq_pkg::CQ_CW'(deq_pkg::CQ_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with count");

  a_rd_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (rd && !rvalid) |=> $stable(rd_ptr_r))
    else $error("read pointer moved on empty queue");

endmodule

`default_nettype wire

>>> sv/deq_back.sv
// deq_back: executes commands against the entry memory, keeps head/tail/count,
// holds the result register. Depends on deq_pkg.
`default_nettype none

module deq_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  input  wire deq_pkg::cmd_t                 cmd,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [deq_pkg::STAT_W-1:0]         out_status,
  output logic signed [deq_pkg::WORD_W-1:0]  out_data_value
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                      state_r, state_nxt;
  deq_pkg::idx_t               head_r, head_nxt;
  deq_pkg::idx_t               tail_r, tail_nxt;
  deq_pkg::cnt_t               count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  deq_pkg::status_t            out_status_r, out_status_nxt;
  logic [deq_pkg::WORD_W-1:0]  out_data_r, out_data_nxt;

  logic [deq_pkg::WORD_W-1:0]  mem [deq_pkg::DEPTH];
  logic [deq_pkg::WORD_W-1:0]  rd_data_r;
  logic                        mem_we, rd_en;
  deq_pkg::idx_t               wr_addr, rd_addr;

  logic                        empty, full, out_free;

  assign empty    = (count_r == '0);
  assign full     = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    wr_addr        = tail_r;
    rd_en          = 1'b0;
    rd_addr        = cmd.at_back ? deq_pkg::idx_dec(tail_r) : head_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd.is_peek && !empty) begin
          // memory read into rd_data_r; S_READ sends the result out once the output is free
          cmd_pop   = 1'b1;
          rd_en     = 1'b1;
          state_nxt = S_READ;
        end else if (cmd_valid && out_free) begin
          cmd_pop        = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = deq_pkg::ST_OK;
          out_data_nxt   = '0;
          if (cmd.is_push) begin
            if (full) begin
              out_status_nxt = deq_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = deq_pkg::cnt_t'(count_r + 1'b1);
              if (cmd.at_back) begin
                wr_addr  = tail_r;
                tail_nxt = deq_pkg::idx_inc(tail_r);
              end else begin
                wr_addr  = deq_pkg::idx_dec(head_r);
                head_nxt = deq_pkg::idx_dec(head_r);
              end
            end
          end else if (cmd.is_pop) begin
            if (empty) begin
              out_status_nxt = deq_pkg::ST_EMPTY;
            end else begin
              count_nxt = deq_pkg::cnt_t'(count_r - 1'b1);
              if (cmd.at_back) begin
                tail_nxt = deq_pkg::idx_dec(tail_r);
              end else begin
                head_nxt = deq_pkg::idx_inc(head_r);
              end
            end
          end else if (cmd.is_peek) begin
            out_status_nxt = deq_pkg::ST_EMPTY;
            out_data_nxt   = '1;
          end else if (cmd.op == deq_pkg::OP_SIZE) begin
            out_data_nxt = deq_pkg::WORD_W'(count_r);
          end else begin
            out_data_nxt = deq_pkg::WORD_W'(empty);
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = deq_pkg::ST_OK;
          out_data_nxt   = rd_data_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_value = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("entry count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && !out_free) |=> (state_r == S_READ))
    else $error("peek result dropped while output stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

>>> sv/double_ended_queue_core.sv
// double_ended_queue_core: top level of the 32-bit double-ended queue.
// Depends on deq_pkg, deq_front, deq_cmd_queue and deq_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_operation[2:0], in_push_value[31:0]
//   out_     output     out_valid / out_stall out_status[1:0], out_data_value[31:0]
//
// push, pop, size and empty words retire one per cycle in the back end while the output is free;
// a peek on a non-empty queue waits in S_READ (registered memory read port) and holds off new commands.
// a result passes the command queue and the result register; a peek also the memory read register.
// reset clears head, tail, count, the command queue and the result valid;
// the entry memory is not cleared and needs no sweep.
// a stalled output holds its word; the two-entry command queue absorbs stalls.
`default_nettype none

module double_ended_queue_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [deq_pkg::OP_W-1:0]          in_operation,
  input  wire logic signed [deq_pkg::WORD_W-1:0] in_push_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [deq_pkg::STAT_W-1:0]             out_status,
  output logic signed [deq_pkg::WORD_W-1:0]      out_data_value
);

  logic          cq_full, cq_wr, cq_rd, cq_rvalid;
  deq_pkg::cmd_t cq_wdata, cq_rdata;

  deq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_push_value (in_push_value),
    .cq_full       (cq_full),
    .cq_wr         (cq_wr),
    .cq_wdata      (cq_wdata)
  );

  deq_cmd_queue u_cq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (cq_wr),
    .wdata  (cq_wdata),
    .full   (cq_full),
    .rd     (cq_rd),
    .rvalid (cq_rvalid),
    .rdata  (cq_rdata)
  );

  deq_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cq_rvalid),
    .cmd            (cq_rdata),
    .cmd_pop        (cq_rd),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_data_value (out_data_value)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
// tb: self-checking bench for double_ended_queue_core; drives random and directed
// operations, predicts every result with a local mirror of the queue state.
// Depends on deq_pkg and double_ended_queue_core.
`default_nettype none

module tb;

  localparam int N_RANDOM    = 1330;
  localparam int GAP_PCT     = 6;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 80;
  localparam int TX_QUIET_LO = 500;
  localparam int TX_QUIET_HI = 800;
  localparam int RX_QUIET_LO = 700;
  localparam int RX_QUIET_HI = 1000;
  localparam int DRAIN_CYC   = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    deq_pkg::op_t               op;
    logic [deq_pkg::WORD_W-1:0] value;
  } deq_word_t;

  typedef struct packed {
    deq_pkg::status_t           status;
    logic [deq_pkg::WORD_W-1:0] data;
  } deq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [deq_pkg::OP_W-1:0] in_operation = '0;
  logic signed [deq_pkg::WORD_W-1:0] in_push_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [deq_pkg::STAT_W-1:0] out_status;
  logic signed [deq_pkg::WORD_W-1:0] out_data_value;

  deq_word_t   ops_to_send[$];
  deq_result_t deq_results_due[$];

  // mirror of the queue contents
  logic [deq_pkg::WORD_W-1:0] mirror_mem [deq_pkg::DEPTH];
  deq_pkg::idx_t mirror_head = '0;
  deq_pkg::idx_t mirror_tail = '0;
  int   mirror_count = 0;

  int gen_level = 0;
  int fail_count = 0;
  int sent_no = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit in_taken = 1'b0;

  double_ended_queue_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_data_value (out_data_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void predict_deq_result(input deq_pkg::op_t op,
                                             input logic [deq_pkg::WORD_W-1:0] word);
    deq_result_t r;
    r.status = deq_pkg::ST_OK;
    r.data = '0;
    case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (mirror_count >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          mirror_head = deq_pkg::idx_t'((mirror_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH);
          mirror_mem[mirror_head] = word;
          mirror_count++;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (mirror_count >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          mirror_mem[mirror_tail] = word;
          mirror_tail = deq_pkg::idx_t'((mirror_tail + 1) % deq_pkg::DEPTH);
          mirror_count++;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (mirror_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          mirror_head = deq_pkg::idx_t'((mirror_head + 1) % deq_pkg::DEPTH);
          mirror_count--;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (mirror_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          mirror_tail = deq_pkg::idx_t'((mirror_tail + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH);
          mirror_count--;
        end
      end
      deq_pkg::OP_PEEK_FRONT: begin
        if (mirror_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
          r.data = '1;
        end else begin
          r.data = mirror_mem[mirror_head];
        end
      end
      deq_pkg::OP_PEEK_BACK: begin
        if (mirror_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
          r.data = '1;
        end else begin
          r.data = mirror_mem[deq_pkg::idx_t'((mirror_tail + deq_pkg::DEPTH - 1) %
                                              deq_pkg::DEPTH)];
        end
      end
      deq_pkg::OP_SIZE: begin
        r.data = deq_pkg::WORD_W'(mirror_count);
      end
      default: begin
        r.data = (mirror_count == 0) ? 32'd1 : 32'd0;
      end
    endcase
    deq_results_due = {deq_results_due, r};
  endfunction

  // queue up one word for the driver and track the fill level it leads to
  function automatic void queue_op(input deq_pkg::op_t op,
                                   input logic [deq_pkg::WORD_W-1:0] value);
    deq_word_t w;
    w.op = op;
    w.value = value;
    ops_to_send = {ops_to_send, w};
    if ((op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK) &&
        gen_level < deq_pkg::DEPTH)
      gen_level++;
    else if ((op == deq_pkg::OP_POP_FRONT || op == deq_pkg::OP_POP_BACK) && gen_level > 0)
      gen_level--;
  endfunction

  function automatic logic [deq_pkg::WORD_W-1:0] pick_value();
    logic [deq_pkg::WORD_W-1:0] v;
    case ($urandom_range(15))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = 32'h0000_0000;
      3: v = 32'hffff_ffff;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // driver: a new word goes out once the previous one was taken
  always @(negedge clk) begin
    deq_word_t nxt_word;
    if (rst_n && (!in_valid || in_taken)) begin
      if (ops_to_send.size() != 0 &&
          ((sent_no >= TX_QUIET_LO && sent_no < TX_QUIET_HI) ||
           $urandom_range(99) >= GAP_PCT)) begin
        nxt_word = ops_to_send[0];
        ops_to_send.delete(0);
        in_valid <= 1'b1;
        in_operation <= nxt_word.op;
        in_push_value <= nxt_word.value;
        sent_no++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off, one quiet window
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle == HOLD_AT)
      hold_left = HOLD_LEN;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_cycle >= RX_QUIET_LO && rx_cycle < RX_QUIET_HI) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < GAP_PCT);
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        predict_deq_result(deq_pkg::op_t'(in_operation), in_push_value);
      end
      if (out_valid && !out_stall) begin
        got.status = deq_pkg::status_t'(out_status);
        got.data = out_data_value;
        if (deq_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: status %0d data %h", got.status, got.data);
        end else begin
          want = deq_results_due[0];
          deq_results_due.delete(0);
          if (got.status !== want.status || got.data !== want.data) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: status exp %0d got %0d, data exp %h got %h",
                       want.status, got.status, want.data, got.data);
          end
        end
      end
    end
  end

  initial begin
    bit filling;
    int r;
    deq_pkg::op_t op;

    // empty-queue cases first, then pushes at both ends with extreme words, peeks, size, and pops back to empty
    queue_op(deq_pkg::OP_EMPTY, '0);
    queue_op(deq_pkg::OP_SIZE, '0);
    queue_op(deq_pkg::OP_PEEK_FRONT, '0);
    queue_op(deq_pkg::OP_PEEK_BACK, '0);
    queue_op(deq_pkg::OP_POP_FRONT, '0);
    queue_op(deq_pkg::OP_POP_BACK, '0);
    queue_op(deq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
    queue_op(deq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    queue_op(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    queue_op(deq_pkg::OP_PUSH_BACK, 32'hffff_ffff);
    queue_op(deq_pkg::OP_PEEK_FRONT, 32'h5555_5555);
    queue_op(deq_pkg::OP_PEEK_BACK, 32'haaaa_aaaa);
    queue_op(deq_pkg::OP_SIZE, '0);
    queue_op(deq_pkg::OP_EMPTY, '0);
    queue_op(deq_pkg::OP_POP_FRONT, '0);
    queue_op(deq_pkg::OP_PEEK_FRONT, '0);
    queue_op(deq_pkg::OP_POP_BACK, '0);
    queue_op(deq_pkg::OP_PEEK_BACK, '0);
    queue_op(deq_pkg::OP_POP_FRONT, '0);
    queue_op(deq_pkg::OP_POP_BACK, '0);
    queue_op(deq_pkg::OP_EMPTY, '0);

    // alternate fill and drain phases so full and empty are both hit often
    filling = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        op = deq_pkg::op_t'($urandom_range(7, 4));
      end else if ($urandom_range(99) < (filling ? 80 : 20)) begin
        op = $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      end else begin
        op = $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
      end
      queue_op(op, pick_value());
      if (filling && gen_level >= deq_pkg::DEPTH && $urandom_range(7) == 0)
        filling = 1'b0;
      else if (!filling && gen_level == 0 && $urandom_range(7) == 0)
        filling = 1'b1;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid)
      @(posedge clk);
    while (deq_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (fail_count == 0 && deq_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/deq_pkg.sv
sv/deq_front.sv
sv/deq_cmd_queue.sv
sv/deq_back.sv
sv/double_ended_queue_core.sv
verif/tb.sv
